>>> sv/lpd_pkg.sv
// Shared types and codes for the length-prefix deframer.
// Holds the result record that flows from the classifier through the queue
// to the output stage. No dependencies.
package lpd_pkg;

  localparam int unsigned LEN_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HCNT_W = 3;

  // Header byte counter values: 0..2 collect, 3 decides, 4 payload phase.
  localparam logic [HCNT_W-1:0] HDR_DECIDE = 3'd3;
  localparam logic [HCNT_W-1:0] HDR_DONE   = 3'd4;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'h0010_0000;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } lpd_kind_t;

  typedef struct packed {
    lpd_kind_t         kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic [LEN_W-1:0]  frame_length;
  } lpd_rec_t;

  // Push side of the result queue, driven by the classifier.
  typedef struct packed {
    logic     push;
    lpd_rec_t rec;
  } lpd_push_t;

  // Head of the result queue, seen by the output stage.
  typedef struct packed {
    logic     valid;
    lpd_rec_t rec;
  } lpd_head_t;

endpackage

>>> sv/lpd_front.sv
// Classifier: accepts received bytes, tracks header and payload framing
// and produces result records. Depends on lpd_pkg.
module lpd_front
  import lpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic                end_of_chunk,
  input  logic                cfg_wr_en,
  input  logic [LEN_W-1:0]    cfg_wr_data,
  output lpd_push_t           push_o
);

  logic [23:0]       hdr_shift_r, hdr_shift_nxt;
  logic [HCNT_W-1:0] hdr_cnt_r,   hdr_cnt_nxt;
  logic [LEN_W-1:0]  exp_len_r,   exp_len_nxt;
  logic [LEN_W-1:0]  remain_r,    remain_nxt;
  logic              disc_r,      disc_nxt;
  logic [LEN_W-1:0]  max_len_r;
  logic [LEN_W-1:0]  hdr_len;

  assign hdr_len = {hdr_shift_r, rx_byte};

  always_comb begin
    hdr_shift_nxt = hdr_shift_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    exp_len_nxt   = exp_len_r;
    remain_nxt    = remain_r;
    disc_nxt      = disc_r;
    push_o        = '0;
    if (fire) begin
      if (disc_r) begin
        if (end_of_chunk) begin
          disc_nxt = 1'b0;
        end
      end else if (hdr_cnt_r < HDR_DECIDE) begin
        hdr_shift_nxt = {hdr_shift_r[15:0], rx_byte};
        hdr_cnt_nxt   = hdr_cnt_r + 1'b1;
      end else if (hdr_cnt_r == HDR_DECIDE) begin
        if (hdr_len > max_len_r) begin
          hdr_shift_nxt            = '0;
          hdr_cnt_nxt              = '0;
          exp_len_nxt              = '0;
          remain_nxt               = '0;
          disc_nxt                 = !end_of_chunk;
          push_o.push              = 1'b1;
          push_o.rec.kind          = KIND_ERROR;
          push_o.rec.frame_length  = hdr_len;
        end else if (hdr_len == '0) begin
          hdr_shift_nxt            = '0;
          hdr_cnt_nxt              = '0;
          exp_len_nxt              = '0;
          remain_nxt               = '0;
          push_o.push              = 1'b1;
          push_o.rec.kind          = KIND_EMPTY;
          push_o.rec.frame_last    = 1'b1;
        end else begin
          hdr_shift_nxt = '0;
          hdr_cnt_nxt   = HDR_DONE;
          exp_len_nxt   = hdr_len;
          remain_nxt    = hdr_len;
        end
      end else begin
        // Payload phase; the remaining count is at least one here.
        push_o.push              = 1'b1;
        push_o.rec.kind          = KIND_PAYLOAD;
        push_o.rec.payload_byte  = rx_byte;
        push_o.rec.frame_length  = exp_len_r;
        push_o.rec.frame_last    = (remain_r == LEN_W'(1));
        if (remain_r == LEN_W'(1)) begin
          hdr_shift_nxt = '0;
          hdr_cnt_nxt   = '0;
          exp_len_nxt   = '0;
          remain_nxt    = '0;
        end else begin
          remain_nxt = remain_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_shift_r <= '0;
      hdr_cnt_r   <= '0;
      exp_len_r   <= '0;
      remain_r    <= '0;
      disc_r      <= 1'b0;
      max_len_r   <= MAX_LEN_RESET;
    end else begin
      hdr_shift_r <= hdr_shift_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      exp_len_r   <= exp_len_nxt;
      remain_r    <= remain_nxt;
      disc_r      <= disc_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

endmodule

>>> sv/lpd_fifo.sv
// Short result queue between the classifier and the output stage.
// Depends on lpd_pkg.
module lpd_fifo
  import lpd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lpd_push_t push_i,
  input  logic      pop,
  output lpd_head_t head_o,
  output logic      full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpd_rec_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign full         = (cnt_r == CNT_W'(DEPTH));
  assign head_o.valid = (cnt_r != '0);
  assign head_o.rec   = mem_r[rd_ptr_r];
  assign do_push      = push_i.push && !full;
  assign do_pop       = pop && head_o.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_i.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue count exceeds depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("result queue count did not rise on push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("result queue count did not fall on pop");

endmodule

>>> sv/lpd_back.sv
// Output stage: takes records from the head of the queue into an output
// register and presents them on the result stream. Depends on lpd_pkg.
module lpd_back
  import lpd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpd_head_t                   head_i,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [BYTE_W+LEN_W-1:0]     out_tdata,
  output logic                        out_tlast,
  output logic [1:0]                  out_tuser
);

  logic     valid_r;
  lpd_rec_t rec_r;

  assign pop        = head_i.valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = {rec_r.frame_length, rec_r.payload_byte};
  assign out_tlast  = rec_r.frame_last;
  assign out_tuser  = rec_r.kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= head_i.rec;
    end
  end

endmodule

>>> sv/length_prefix_deframer.sv
// Length-prefix deframer: one byte per cycle in, payload bytes and frame events out.
// Each result passes through the result queue and then the output register before it appears on out_*.
// Throughput: one byte per cycle; in_tready drops only when the result queue is full.
// Reset (rst_n low, synchronous) clears framing, the queue and the output register,
// and sets the maximum payload length to 1048576.
module length_prefix_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Received byte stream.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // [7:0] rx_byte
  input  logic                    in_tlast,   // end_of_chunk
  // Result stream.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [39:0]             out_tdata,  // [7:0] payload_byte, [39:8] frame_length
  output logic                    out_tlast,  // frame_last
  output logic [1:0]              out_tuser,  // [1:0] kind
  // Maximum payload length register.
  input  logic                    cfg_wr_en,
  input  logic [31:0]             cfg_wr_data
);

  // The front part classifies each accepted byte in the cycle of its transfer
  // and pushes at most one record into the queue. The back part drains the
  // queue into an output register, so a stalled result stream never blocks
  // bytes while the queue has room.
  lpd_push_t push;
  lpd_head_t head;
  logic      pop;
  logic      full;
  logic      in_fire;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  lpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .rx_byte      (in_tdata),
    .end_of_chunk (in_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .push_o       (push)
  );

  // The queue is never full when a byte is accepted, so no record is lost.
  lpd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .head_o (head),
    .full   (full)
  );

  lpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_i     (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> test/deframe_checker.sv
// Checker for the length-prefix deframer: it watches the byte stream, the result stream
// and the register port, predicts every result and compares it field by field.
// Depends on lpd_pkg for the result record and the kind codes.
module deframe_checker
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tlast,    // end_of_chunk
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,   // [7:0] payload_byte, [39:8] frame_length
  input  logic        out_tlast,   // frame_last
  input  logic [1:0]  out_tuser,   // [1:0] kind
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          mismatch_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] length_limit;
  logic [23:0] hdr_shift;
  logic [2:0]  hdr_count;
  logic [31:0] frame_len;
  logic [31:0] bytes_done;
  logic        dropping;
  lpd_rec_t    due_q[$];

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  task automatic clear_frame();
    hdr_shift  = '0;
    hdr_count  = '0;
    frame_len  = '0;
    bytes_done = '0;
  endtask

  // Works out what one accepted byte does to the framing and queues its result, if any.
  task automatic decode_rx_byte(input logic [7:0] rx, input logic eoc);
    logic [31:0] len;
    logic [31:0] next_done;
    len       = {hdr_shift, rx};
    next_done = bytes_done + 32'd1;
    if (dropping) begin
      if (eoc) dropping = 1'b0;
    end else if (hdr_count < HDR_DECIDE) begin
      hdr_shift = {hdr_shift[15:0], rx};
      hdr_count = hdr_count + 3'd1;
    end else if (hdr_count == HDR_DECIDE) begin
      if (len > length_limit) begin
        clear_frame();
        dropping = !eoc;
        due_q.push_back('{kind: KIND_ERROR, payload_byte: 8'h00, frame_last: 1'b0,
                          frame_length: len});
      end else if (len == 32'd0) begin
        clear_frame();
        due_q.push_back('{kind: KIND_EMPTY, payload_byte: 8'h00, frame_last: 1'b1,
                          frame_length: 32'd0});
      end else begin
        hdr_shift  = '0;
        hdr_count  = HDR_DONE;
        frame_len  = len;
        bytes_done = '0;
      end
    end else begin
      due_q.push_back('{kind: KIND_PAYLOAD, payload_byte: rx,
                        frame_last: (next_done >= frame_len), frame_length: frame_len});
      if (next_done >= frame_len) clear_frame();
      else bytes_done = next_done;
    end
  endtask

  always @(posedge clk) begin : watch
    lpd_rec_t want;
    if (!rst_n) begin
      length_limit = MAX_LEN_RESET;
      dropping     = 1'b0;
      clear_frame();
      due_q.delete();
    end else begin
      if (cfg_wr_en) length_limit = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result with nothing due: kind %0d byte %02h last %0b len %0d",
                     $time, out_tuser, out_tdata[7:0], out_tlast, out_tdata[39:8]);
          mismatch_count++;
        end else begin
          want = due_q.pop_front();
          if (out_tuser !== want.kind || out_tdata[7:0] !== want.payload_byte ||
              out_tlast !== want.frame_last || out_tdata[39:8] !== want.frame_length) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch: want kind %0d byte %02h last %0b len %0d, %s",
                       $time, want.kind, want.payload_byte, want.frame_last,
                       want.frame_length,
                       $sformatf("got kind %0d byte %02h last %0b len %0d", out_tuser,
                                 out_tdata[7:0], out_tlast, out_tdata[39:8]));
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_rx_byte(in_tdata, in_tlast);
    end
    results_due = due_q.size();
  end

endmodule

>>> test/tb.sv
// Top of the deframer testbench: clock, reset, byte stimulus, result back-pressure and the
// verdict. Depends on lpd_pkg, length_prefix_deframer and deframe_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpd_pkg::*;

  // A long hold-off on the result side plus random idling stays well below this limit.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 145;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] rx_byte
  logic        in_tlast;    // end_of_chunk
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // [7:0] payload_byte, [39:8] frame_length
  logic        out_tlast;   // frame_last
  logic [1:0]  out_tuser;   // [1:0] kind
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  int          mismatch_count;
  int          results_due;

  // Stimulus-side knobs. The stimulus keeps its own copy of the length limit so that it
  // knows when a header will be rejected and the block will start dropping bytes.
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_off_req;
  logic [31:0] limit_now;
  int unsigned quiet_cycles = 0;

  length_prefix_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  deframe_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result-side back-pressure. A hold-off request from the stimulus makes the receiver
  // refuse every transfer for a long stretch, so the result queue inside the block fills
  // and in_tready has to drop while bytes are still being offered.
  initial begin
    int unsigned hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_tready  <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: the run is abandoned once nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte, with a random run of idle cycles in front of it, and returns at the
  // edge where the transfer takes place. tvalid is only lowered when a gap is inserted.
  task automatic push_byte(input logic [7:0] rx, input logic eoc);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    in_tlast  <= eoc;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Lets every due result come out, then keeps idling so that a byte with no
  // result of its own (header or dropped byte) has surely passed the two-stage pipeline.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    limit_now    = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Chooses a frame length against the current limit: some empty frames, some rejected
  // headers (often just one above the limit), some exactly at the limit when that is
  // short enough, the rest short payloads with now and then a longer one.
  function automatic logic [31:0] pick_length();
    int unsigned roll;
    logic [31:0] cap;
    roll = $urandom_range(99);
    cap  = (limit_now < 32'd12) ? limit_now : 32'd12;
    if (roll < 8) return 32'd0;
    if (roll < 20 && limit_now != 32'hFFFF_FFFF) begin
      if ($urandom_range(3) == 0) return limit_now + 32'd1;
      return $urandom_range(32'hFFFF_FFFF, limit_now + 32'd1);
    end
    if (roll < 28 && limit_now <= 32'd40) return limit_now;
    if (cap == 32'd0) return 32'd0;
    if (roll >= 96 && limit_now >= 32'd40) return 32'd40;
    return $urandom_range(cap, 1);
  endfunction

  // Sends one complete frame with end-of-chunk marks scattered at random. After a
  // rejected header the bytes up to the next mark are dropped, so a short run of junk
  // closed by a marked byte follows, unless the header's last byte already closed the chunk.
  task automatic send_frame(input logic [31:0] len, inout int unsigned sent);
    logic eoc;
    int unsigned junk;
    eoc = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      eoc = ($urandom_range(5) == 0);
      push_byte(len[8*i +: 8], eoc);
    end
    sent += 4;
    if (len > limit_now) begin
      if (!eoc) begin
        junk = $urandom_range(3);
        repeat (junk) push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b1);
      end
    end else begin
      for (int unsigned k = 0; k < len; k++) push_byte(8'($urandom), $urandom_range(5) == 0);
      sent += len;
    end
  endtask

  task automatic run_frames(input int unsigned items);
    int unsigned sent;
    sent = 0;
    while (sent < items) send_frame(pick_length(), sent);
  endtask

  initial begin
    // Directed opening, each entry {end_of_chunk, rx_byte}, under the reset limit:
    // a one-byte frame, an empty frame, a header one above the limit whose last byte
    // closes the chunk (nothing left to drop), an all-ones header followed by two dropped
    // bytes, and a two-byte frame with a chunk mark inside its header that changes nothing.
    logic [8:0] opening [25];
    opening = '{9'h000, 9'h000, 9'h000, 9'h001, 9'h1FF,
                9'h000, 9'h000, 9'h000, 9'h000,
                9'h000, 9'h010, 9'h000, 9'h101,
                9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h17E,
                9'h000, 9'h100, 9'h000, 9'h002, 9'h000, 9'h0FF};
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rst_n         = 1'b0;
    hold_off_req  = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 50;
    limit_now     = MAX_LEN_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) push_byte(opening[i][7:0], opening[i][8]);

    drain();
    write_limit(32'd16);
    run_frames(PHASE_ITEMS);

    // With a zero limit every header that is not empty is rejected.
    drain();
    write_limit(32'd0);
    run_frames(PHASE_ITEMS);

    // Swap the idling of the two sides. The limit is raised between the second and
    // third header bytes of a frame: the length is only judged on the fourth byte, so
    // this three-byte frame must be accepted under the new setting.
    send_idle_pct = 50;
    recv_idle_pct = 14;
    drain();
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    drain();
    write_limit(32'hFFFF_FFFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0);
    repeat (3) push_byte(8'($urandom), 1'b0);
    run_frames(PHASE_ITEMS);

    drain();
    write_limit(32'd1);
    run_frames(PHASE_ITEMS);

    // Neither side idles from here on, apart from one long receiver hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    write_limit(32'd5);
    run_frames(PHASE_ITEMS);

    drain();
    write_limit(32'hFFFF_FFFF);
    hold_off_req = 1'b1;
    run_frames(PHASE_ITEMS);

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lpd_pkg.sv
sv/lpd_front.sv
sv/lpd_fifo.sv
sv/lpd_back.sv
sv/length_prefix_deframer.sv
test/deframe_checker.sv
test/tb.sv
